// File: rtl/core/pcs_pkg.sv
// Package with shared types and constants for the PUCT child selection block.
`default_nettype none
package pcs_pkg;

  // Field widths of the channels.
  localparam int unsigned VSUM_W  = 32;
  localparam int unsigned VIS_W   = 24;
  localparam int unsigned PRIOR_W = 16;
  localparam int unsigned CW_W    = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned SCORE_W = 48;

  // Datapath widths of the shared iterative unit.
  localparam int unsigned ROOT_W  = 20;  // sqrt of a 40-bit radicand
  localparam int unsigned NUM_W   = 34;  // signed numerator, magnitude fits unsigned
  localparam int unsigned DEN_W   = 25;  // child_visits + 1
  localparam int unsigned ACC_W   = 40;  // left-aligned operand shift register
  localparam int unsigned REM_W   = 26;  // partial remainder
  localparam int unsigned CNT_W   = 6;

  localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd20;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd34;

  localparam logic [CW_W-1:0]    CW_RESET  = 16'd10240;
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Operation of the shared unit.
  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } pcs_mode_t;

  // Command from the sequencer to the shared unit.
  typedef struct packed {
    logic      start;
    pcs_mode_t mode;
  } pcs_cmd_t;

  // Status from the shared unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pcs_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/pcs_channels.sv
// Channel interfaces for child input, selection result and configuration.
`default_nettype none
interface pcs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_sum;
  logic [23:0] child_visits;
  logic [15:0] prior;
  logic [23:0] parent_visits;
  logic        last;

  modport source (output valid, value_sum, child_visits, prior, parent_visits, last,
                  input ready);
  modport sink (input valid, value_sum, child_visits, prior, parent_visits, last,
                output ready);
endinterface

interface pcs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  best_index;
  logic [47:0] best_score;

  modport source (output valid, best_index, best_score, input ready);
  modport sink (input valid, best_index, best_score, output ready);
endinterface

interface pcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] explore_weight;

  modport source (output valid, explore_weight, input ready);
  modport sink (input valid, explore_weight, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pcs_iter_unit.sv
// Shared iterative compare-subtract unit for restoring square root and division.
`default_nettype none
module pcs_iter_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pcs_pkg::pcs_cmd_t          cmd,
  input  wire logic [pcs_pkg::ACC_W-1:0]  op_a,
  input  wire logic [pcs_pkg::DEN_W-1:0]  op_b,
  output pcs_pkg::pcs_stat_t              stat,
  output logic [pcs_pkg::NUM_W-1:0]       res
);
  import pcs_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  pcs_mode_t        mode_r;
  logic [ACC_W-1:0] acc_r;
  logic [REM_W-1:0] rem_r;
  logic [NUM_W-1:0] res_r;
  logic [DEN_W-1:0] den_r;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] subtrahend;
  logic [REM_W:0]   diff;
  logic             ge;

  // One step: bring down the next operand bits and try the subtraction.
  always_comb begin
    if (mode_r == MODE_SQRT) begin
      shifted    = {rem_r[REM_W-3:0], acc_r[ACC_W-1 -: 2]};
      subtrahend = {{(REM_W-ROOT_W-2){1'b0}}, res_r[ROOT_W-1:0], 2'b01};
    end else begin
      shifted    = {rem_r[REM_W-2:0], acc_r[ACC_W-1]};
      subtrahend = {{(REM_W-DEN_W){1'b0}}, den_r};
    end
    diff = {1'b0, shifted} - {1'b0, subtrahend};
    ge   = ~diff[REM_W];
  end

  // Step counter and operand, remainder and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        mode_r <= cmd.mode;
        cnt_r  <= (cmd.mode == MODE_SQRT) ? SQRT_STEPS - 6'd1 : DIV_STEPS - 6'd1;
        acc_r  <= op_a;
        den_r  <= op_b;
        rem_r  <= '0;
        res_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[REM_W-1:0] : shifted;
        res_r <= {res_r[NUM_W-2:0], ge};
        acc_r <= (mode_r == MODE_SQRT) ? {acc_r[ACC_W-3:0], 2'b00} : {acc_r[ACC_W-2:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// File: rtl/core/puct_child_select.sv
// Top level of the PUCT child selection block with sequencer and running argmax.
//
//   channel  direction  payload
//   in_ch    sink       value_sum, child_visits, prior, parent_visits, last
//   out_ch   source     best_index, best_score
//   cfg_ch   sink       explore_weight
//
// A new child is accepted only after the previous one is done. The first child of a
// selection has the shared compare-subtract unit run a 20-step square root of the
// parent visit count first; every child within MAX_CHILDREN then runs a 34-step
// division, and children past that limit skip the arithmetic.
// Reset is synchronous; it restores explore_weight to 2.5 and clears the selection.
// The result sits in an output register; a new child is taken while it waits,
// and only a second result stalls until the first one is taken.
`default_nettype none
module puct_child_select #(
  parameter int unsigned MAX_CHILDREN = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pcs_in_if.sink    in_ch,
  pcs_out_if.source out_ch,
  pcs_cfg_if.sink   cfg_ch
);
  import pcs_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_CHILDREN + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHILDREN);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_DV_GO,
    ST_DV_WAIT,
    ST_UPDATE
  } state_t;

  state_t                 state_r;
  logic [CW_W-1:0]        explore_weight_r;
  logic [POS_W-1:0]       pos_r;
  logic                   have_best_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [IDX_W-1:0]       best_index_r;
  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_index_r;
  logic [SCORE_W-1:0]     out_score_r;

  // Captured child fields and datapath registers.
  logic [VSUM_W-1:0]      vsum_r;
  logic [VIS_W-1:0]       cvis_r;
  logic [PRIOR_W-1:0]     prior_r;
  logic [VIS_W-1:0]       parent_root_r;
  logic                   last_r;
  logic                   scored_r;
  logic [ROOT_W-1:0]      s_r;
  logic [CW_W+ROOT_W-1:0] prod1_r;
  logic [CW_W+ROOT_W+PRIOR_W-1:0] prod2_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [SCORE_W-1:0] score_r;

  pcs_cmd_t          cmd;
  pcs_stat_t         stat;
  logic [ACC_W-1:0]  op_a;
  logic [DEN_W-1:0]  op_b;
  logic [NUM_W-1:0]  unit_res;

  logic [NUM_W-1:0]  num_mag;
  logic [NUM_W:0]    quot_signed;
  logic              take;
  logic              out_block;
  logic              deliver;
  logic signed [SCORE_W-1:0] win_score;
  logic [IDX_W-1:0]  win_index;

  // Operands for the shared unit.
  always_comb begin
    num_mag = num_r[NUM_W-1] ? (~num_r + 1'b1) : num_r;
    cmd.start = (state_r == ST_SQ_GO) || (state_r == ST_DV_GO);
    cmd.mode  = (state_r == ST_SQ_GO) ? MODE_SQRT : MODE_DIV;
    if (state_r == ST_SQ_GO) begin
      op_a = {parent_root_r, 16'd0};
    end else begin
      op_a = {num_mag, {(ACC_W-NUM_W){1'b0}}};
    end
    op_b = {1'b0, cvis_r} + 25'd1;
  end

  // Quotient with the sign of the numerator, truncated toward zero.
  assign quot_signed = num_r[NUM_W-1] ? -{1'b0, unit_res} : {1'b0, unit_res};

  // Running argmax: the first scored child always wins, later ones only when strictly greater.
  always_comb begin
    take      = scored_r && (!have_best_r || (score_r > best_score_r));
    win_score = take ? score_r : best_score_r;
    win_index = take ? IDX_W'(pos_r) : best_index_r;
    out_block = last_r && out_valid_r && !out_ch.ready;
    deliver   = (state_r == ST_UPDATE) && last_r && !out_block;
  end

  pcs_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .op_a  (op_a),
    .op_b  (op_b),
    .stat  (stat),
    .res   (unit_res)
  );

  // Sequencer, selection state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      explore_weight_r <= CW_RESET;
      pos_r            <= '0;
      have_best_r      <= 1'b0;
      best_score_r     <= SCORE_MIN;
      best_index_r     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        explore_weight_r <= cfg_ch.explore_weight;
      end
      // A new result is loaded, or the waiting one leaves once it is taken.
      out_valid_r <= deliver | (out_valid_r & ~out_ch.ready);
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            vsum_r   <= in_ch.value_sum;
            cvis_r   <= in_ch.child_visits;
            prior_r  <= in_ch.prior;
            last_r   <= in_ch.last;
            scored_r <= (pos_r < POS_LIMIT);
            if (pos_r == '0) begin
              parent_root_r <= in_ch.parent_visits;
              state_r       <= ST_SQ_GO;
            end else if (pos_r < POS_LIMIT) begin
              state_r <= ST_MUL1;
            end else begin
              state_r <= ST_UPDATE;
            end
          end
        end
        ST_SQ_GO: begin
          state_r <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (stat.done) begin
            s_r     <= unit_res[ROOT_W-1:0];
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod1_r <= {{ROOT_W{1'b0}}, explore_weight_r} * {{CW_W{1'b0}}, s_r};
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2_r <= (CW_W+ROOT_W+PRIOR_W)'(prod1_r) * (CW_W+ROOT_W+PRIOR_W)'(prior_r);
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          num_r   <= $signed({{(NUM_W-VSUM_W){vsum_r[VSUM_W-1]}}, vsum_r})
                   + $signed({2'b00, prod2_r[CW_W+ROOT_W+PRIOR_W-1:20]});
          state_r <= ST_DV_GO;
        end
        ST_DV_GO: begin
          state_r <= ST_DV_WAIT;
        end
        ST_DV_WAIT: begin
          if (stat.done) begin
            score_r <= {{(SCORE_W-NUM_W-1){quot_signed[NUM_W]}}, quot_signed};
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (!out_block) begin
            if (last_r) begin
              out_index_r  <= win_index;
              out_score_r  <= win_score;
              pos_r        <= '0;
              have_best_r  <= 1'b0;
              best_score_r <= SCORE_MIN;
              best_index_r <= '0;
            end else begin
              best_score_r <= win_score;
              best_index_r <= win_index;
              have_best_r  <= have_best_r | scored_r;
              if (scored_r) begin
                pos_r <= pos_r + 1'b1;
              end
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_index = out_index_r;
  assign out_ch.best_score = out_score_r;

`ifndef SYNTHESIS
  // The child count never runs past the limit.
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("child position beyond limit");

  // Once a child has been counted a running best exists.
  a_best_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) |-> have_best_r)
    else $error("children counted without a running best");

  // The shared unit only finishes while the sequencer waits for it.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> ((state_r == ST_SQ_WAIT) || (state_r == ST_DV_WAIT)))
    else $error("shared unit finished outside a wait state");

  // Delivering a result clears the selection and leaves the result valid.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPDATE) && last_r && !out_block) |=>
      (!have_best_r && (pos_r == '0) && out_valid_r))
    else $error("selection not cleared after result");
`endif

endmodule
`default_nettype wire
